>>> design/itt_pkg.sv
// Shared types and constants for the interval timer table.
// Used by itt_calc and interval_timer_table; depends on nothing else.
`default_nettype none

package itt_pkg;

  // Default number of timer slots.
  localparam int MAX_TIMERS_DEF = 16;

  // A tick reports at most this many fired timers.
  localparam int RES_MAX = 16;
  localparam int NF_W    = $clog2(RES_MAX + 1);

  // Request type codes.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Result kinds.
  typedef enum logic [2:0] {
    K_SET_OK   = 3'd0,
    K_SET_FULL = 3'd1,
    K_CLEAR    = 3'd2,
    K_FIRED    = 3'd3,
    K_IDLE     = 3'd4
  } kind_t;

  // Sequencer states.
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // One stored timer.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] delay;
    logic [63:0] due;
    logic        once;
  } entry_t;

  // Outputs of the shared time arithmetic unit.
  typedef struct packed {
    logic        fire;
    logic [63:0] next_due;
    logic [63:0] set_due;
  } calc_res_t;

endpackage

`default_nettype wire

>>> design/itt_calc.sv
// Shared time arithmetic unit: due test and rescheduling of one timer entry.
// Depends on itt_pkg for the result struct.
`default_nettype none

module itt_calc import itt_pkg::*; (
  input  wire logic [63:0] now,
  input  wire logic [63:0] due,
  input  wire logic [31:0] delay,
  output calc_res_t        res
);

  logic [63:0] sum_due;
  logic [63:0] sum_now;

  // Both candidate due times are formed side by side.
  assign sum_due = due + {32'd0, delay};
  assign sum_now = now + {32'd0, delay};

  // A periodic entry that has fallen behind restarts from the present time.
  always_comb begin
    res.fire     = (due <= now);
    res.next_due = (sum_due <= now) ? sum_now : sum_due;
    res.set_due  = sum_now;
  end

endmodule

`default_nettype wire

>>> design/interval_timer_table.sv
// Interval timer table top level: request sequencer, slot memory and result output.
// Depends on itt_pkg and itt_calc.
`default_nettype none

// A table of one-shot and periodic millisecond timers kept in a single-port-write,
// single-port-read slot memory, newest entry at slot 0. A request is taken when start
// is high and busy is low. Every request except a set on a full table walks the live
// entries once through the memory read port, one entry per cycle, through one shared
// add and compare unit. Busy stays high while the walk runs, or for a single cycle
// when the table is empty or a set finds it full. The last result appears in the
// same cycle that busy falls, and a new request can be taken in that same cycle.
// Results come out on out_strobe, one per cycle at most, and are not held: the
// receiver must take each one in the cycle it appears. The last result of a request
// carries out_last. A tick gives one result per fired timer, newest first, at most
// sixteen, or a single nothing-fired result. Request type 3 is dropped with no
// result. No clearing pass is needed after reset; a live-entry count marks which
// slots hold timers.
module interval_timer_table import itt_pkg::*; #(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_elapsed_ms,
  input  wire logic [31:0] in_delay_ms,
  input  wire logic        in_one_shot,
  input  wire logic [31:0] in_timer_id,
  output logic             out_strobe,
  output logic [2:0]       out_result_kind,
  output logic [31:0]      out_result_id,
  output logic             out_last
);

  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);

  // Slot memory and its read register.
  entry_t slot_mem_r [MAX_TIMERS];
  entry_t rd_q_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // Sequencer and datapath registers.
  state_t        state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [31:0]   delay_r, delay_nxt;
  logic          once_r, once_nxt;
  logic [31:0]   tid_r, tid_nxt;
  logic [63:0]   now_r, now_nxt;
  logic [31:0]   next_id_r, next_id_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] wptr_r, wptr_nxt;
  logic [NF_W-1:0] nfired_r, nfired_nxt;
  logic          found_r, found_nxt;
  logic          p1_vld_r, p1_vld_nxt;
  logic [AW-1:0] p1_addr_r, p1_addr_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [31:0]   pend_id_r, pend_id_nxt;
  logic          ostb_r, ostb_nxt;
  kind_t         okind_r, okind_nxt;
  logic [31:0]   oid_r, oid_nxt;
  logic          olast_r, olast_nxt;

  logic      accept;
  logic      full;
  logic      issue_ok;
  logic      finish;
  logic [31:0] calc_delay;
  calc_res_t calc_res;

  assign accept = start && (state_r == ST_IDLE);
  assign full   = (cnt_r == CW'(MAX_TIMERS));

  // A set walks downward to shift entries; tick and clear walk upward.
  assign issue_ok = (op_r == REQ_SET) ? (rptr_r != '0) : (rptr_r < cnt_r);
  assign finish   = (state_r == ST_RUN) && !issue_ok && !p1_vld_r;

  // Shared arithmetic unit sees the entry in the read register, or the new delay on set.
  assign calc_delay = (op_r == REQ_SET) ? delay_r : rd_q_r.delay;

  itt_calc u_calc (
    .now   (now_r),
    .due   (rd_q_r.due),
    .delay (calc_delay),
    .res   (calc_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (in_req_type != REQ_UNUSED)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory access and result generation.
  always_comb begin
    op_nxt       = op_r;
    delay_nxt    = delay_r;
    once_nxt     = once_r;
    tid_nxt      = tid_r;
    now_nxt      = now_r;
    next_id_nxt  = next_id_r;
    cnt_nxt      = cnt_r;
    rptr_nxt     = rptr_r;
    wptr_nxt     = wptr_r;
    nfired_nxt   = nfired_r;
    found_nxt    = found_r;
    p1_vld_nxt   = 1'b0;
    p1_addr_nxt  = p1_addr_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    ostb_nxt     = 1'b0;
    okind_nxt    = okind_r;
    oid_nxt      = oid_r;
    olast_nxt    = olast_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = wptr_r[AW-1:0];
    wr_data      = rd_q_r;

    case (state_r)
      ST_IDLE: begin
        // Latch the request and prime the walk.
        if (accept) begin
          op_nxt       = in_req_type;
          delay_nxt    = in_delay_ms;
          once_nxt     = in_one_shot;
          tid_nxt      = in_timer_id;
          wptr_nxt     = '0;
          nfired_nxt   = '0;
          found_nxt    = 1'b0;
          pend_vld_nxt = 1'b0;
          if (in_req_type == REQ_TICK) begin
            now_nxt = now_r + {48'd0, in_elapsed_ms};
          end
          if (in_req_type == REQ_SET) begin
            rptr_nxt = full ? '0 : cnt_r;
          end else begin
            rptr_nxt = '0;
          end
        end
      end
      ST_RUN: begin
        // Issue the next memory read.
        if (issue_ok) begin
          rd_en      = 1'b1;
          p1_vld_nxt = 1'b1;
          if (op_r == REQ_SET) begin
            rd_addr  = AW'(rptr_r - 1'b1);
            rptr_nxt = rptr_r - 1'b1;
          end else begin
            rd_addr  = rptr_r[AW-1:0];
            rptr_nxt = rptr_r + 1'b1;
          end
          p1_addr_nxt = rd_addr;
        end

        // Process the entry that the memory returned.
        if (p1_vld_r) begin
          if (op_r == REQ_SET) begin
            wr_en   = 1'b1;
            wr_addr = AW'(p1_addr_r + 1'b1);
          end else if (op_r == REQ_CLEAR) begin
            if (!found_r && (rd_q_r.id == tid_r)) begin
              found_nxt = 1'b1;
            end else begin
              wr_en    = 1'b1;
              wptr_nxt = wptr_r + 1'b1;
            end
          end else begin
            if (calc_res.fire && (nfired_r < NF_W'(RES_MAX))) begin
              nfired_nxt = nfired_r + 1'b1;
              // The previous fired result goes out now; this one waits.
              if (pend_vld_r) begin
                ostb_nxt  = 1'b1;
                okind_nxt = K_FIRED;
                oid_nxt   = pend_id_r;
                olast_nxt = 1'b0;
              end
              pend_vld_nxt = 1'b1;
              pend_id_nxt  = rd_q_r.id;
              if (!rd_q_r.once) begin
                wr_en       = 1'b1;
                wr_data.due = calc_res.next_due;
                wptr_nxt    = wptr_r + 1'b1;
              end
            end else begin
              wr_en    = 1'b1;
              wptr_nxt = wptr_r + 1'b1;
            end
          end
        end

        // Close the request with its final result.
        if (finish) begin
          ostb_nxt  = 1'b1;
          olast_nxt = 1'b1;
          oid_nxt   = '0;
          if (op_r == REQ_SET) begin
            if (full) begin
              okind_nxt = K_SET_FULL;
            end else begin
              wr_en         = 1'b1;
              wr_addr       = '0;
              wr_data.id    = next_id_r;
              wr_data.delay = delay_r;
              wr_data.due   = calc_res.set_due;
              wr_data.once  = once_r;
              okind_nxt     = K_SET_OK;
              oid_nxt       = next_id_r;
              next_id_nxt   = next_id_r + 1'b1;
              cnt_nxt       = cnt_r + 1'b1;
            end
          end else if (op_r == REQ_CLEAR) begin
            okind_nxt = K_CLEAR;
            cnt_nxt   = wptr_r;
          end else begin
            cnt_nxt = wptr_r;
            if (pend_vld_r) begin
              okind_nxt = K_FIRED;
              oid_nxt   = pend_id_r;
            end else begin
              okind_nxt = K_IDLE;
            end
            pend_vld_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= slot_mem_r[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      op_r       <= REQ_TICK;
      now_r      <= '0;
      next_id_r  <= 32'd1;
      cnt_r      <= '0;
      rptr_r     <= '0;
      wptr_r     <= '0;
      nfired_r   <= '0;
      found_r    <= 1'b0;
      p1_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      ostb_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      op_r       <= op_nxt;
      now_r      <= now_nxt;
      next_id_r  <= next_id_nxt;
      cnt_r      <= cnt_nxt;
      rptr_r     <= rptr_nxt;
      wptr_r     <= wptr_nxt;
      nfired_r   <= nfired_nxt;
      found_r    <= found_nxt;
      p1_vld_r   <= p1_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      ostb_r     <= ostb_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    delay_r   <= delay_nxt;
    once_r    <= once_nxt;
    tid_r     <= tid_nxt;
    p1_addr_r <= p1_addr_nxt;
    pend_id_r <= pend_id_nxt;
    okind_r   <= okind_nxt;
    oid_r     <= oid_nxt;
    olast_r   <= olast_nxt;
  end

  // Port outputs.
  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = ostb_r;
  assign out_result_kind = okind_r;
  assign out_result_id   = oid_r;
  assign out_last        = olast_r;

  // The live-entry count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_TIMERS))
    else $error("live entry count exceeds table size");

  // Compaction never writes ahead of the read walk.
  a_wptr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (op_r != REQ_SET) |-> (wptr_r <= rptr_r))
    else $error("compaction write pointer passed read pointer");

  // Every completed request shows its final result as busy drops.
  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> (out_strobe && out_last))
    else $error("request finished without a final result");

  // Only fired results can be followed by more results of the same request.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_result_kind != K_FIRED) |-> out_last)
    else $error("non-fired result not marked last");

  // Kinds without an id carry zero.
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ((out_result_kind == K_SET_FULL) || (out_result_kind == K_CLEAR) ||
                   (out_result_kind == K_IDLE)) |-> (out_result_id == 32'd0))
    else $error("result id not zero");

endmodule

`default_nettype wire
